FILE: sv/dap_pkg.sv
// ---------------------------------------------------------------------------
// dap_pkg: shared types and constants of the decimal amount parser
// Character codes, status codes, register indexes, the record handed from
// the byte scanner to the scaling pipeline, and the power-of-ten table.
// ---------------------------------------------------------------------------
package dap_pkg;

	localparam int AmountW = 64;
	localparam int PlacesW = 5;

	localparam logic [PlacesW-1:0] PLACES_MAX = 5'd19;
	localparam logic [PlacesW-1:0] COUNT_SAT  = 5'd31;

	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_POINT = 8'h2E;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_CR    = 8'h0D;

	typedef enum logic [2:0] {
		ST_OK                = 3'd0,
		ST_TOO_MANY_DECIMALS = 3'd1,
		ST_EMPTY             = 3'd2,
		ST_BAD_CHAR          = 3'd3,
		ST_OVERFLOW          = 3'd4,
		ST_BELOW_MIN         = 3'd5
	} status_t;

	typedef enum logic {
		REG_DECIMAL_PLACES = 1'b0,
		REG_MINIMUM_AMOUNT = 1'b1
	} reg_index_t;

	// finished string: accumulated digits, missing power of ten, early status
	typedef struct packed {
		logic [AmountW-1:0] accum;
		logic [PlacesW-1:0] exp;
		status_t            code;
	} fin_t;

	function automatic logic [AmountW-1:0] pow10(input logic [PlacesW-1:0] e);
		logic [AmountW-1:0] r;
		case (e)
			5'd0:    r = 64'd1;
			5'd1:    r = 64'd10;
			5'd2:    r = 64'd100;
			5'd3:    r = 64'd1000;
			5'd4:    r = 64'd10000;
			5'd5:    r = 64'd100000;
			5'd6:    r = 64'd1000000;
			5'd7:    r = 64'd10000000;
			5'd8:    r = 64'd100000000;
			5'd9:    r = 64'd1000000000;
			5'd10:   r = 64'd10000000000;
			5'd11:   r = 64'd100000000000;
			5'd12:   r = 64'd1000000000000;
			5'd13:   r = 64'd10000000000000;
			5'd14:   r = 64'd100000000000000;
			5'd15:   r = 64'd1000000000000000;
			5'd16:   r = 64'd10000000000000000;
			5'd17:   r = 64'd100000000000000000;
			5'd18:   r = 64'd1000000000000000000;
			5'd19:   r = 64'd10000000000000000000;
			default: r = 64'd1;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/dap_if.sv
// ---------------------------------------------------------------------------
// dap_byte_if / dap_result_if: valid-ready channels of the amount parser
// One interface for the incoming text bytes, one for the parse results.
// ---------------------------------------------------------------------------
interface dap_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       has_char;
	logic       last_char;

	modport source (output valid, output char_code, output has_char, output last_char,
		input ready);
	modport sink (input valid, input char_code, input has_char, input last_char,
		output ready);
endinterface

interface dap_result_if;
	logic        valid;
	logic        ready;
	logic [63:0] amount;
	logic [2:0]  status;

	modport source (output valid, output amount, output status, input ready);
	modport sink (input valid, input amount, input status, output ready);
endinterface

FILE: sv/decimal_amount_parser.sv
// ---------------------------------------------------------------------------
// decimal_amount_parser: decimal text to scaled fixed-point amount
// Takes amount text one byte per transaction and returns one result per
// string: the value scaled to the configured decimal places, with status.
// ---------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  chars     in   valid/ready    char_code[7:0], has_char, last_char
//  result    out  valid/ready    amount[63:0], status[2:0]
//  cfg       in   cfg_wen        cfg_index[0], cfg_data[63:0]
//
// One byte is taken every cycle while chars is not stalled; the scanner
// updates its string state once per byte.
// After the string's last byte is taken, it passes the input and handoff
// registers, then the partial-product multiply, overflow and result stages.
// Backpressure on result fills the scaling stages, then stalls chars only
// when a last byte cannot hand off its string.
// Reset restores decimal_places 2, minimum_amount 1 and an empty string.
// ---------------------------------------------------------------------------
module decimal_amount_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  dap_pkg::reg_index_t cfg_index,
	input  logic [63:0] cfg_data,
	dap_byte_if.sink    chars,
	dap_result_if.source result
);
	import dap_pkg::*;

	logic [PlacesW-1:0] places_q;
	logic [AmountW-1:0] minimum_q;
	logic [PlacesW-1:0] places_eff;

	logic               fin_valid;
	logic               fin_ready;
	fin_t               fin;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			places_q  <= 5'd2;
			minimum_q <= 64'd1;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_DECIMAL_PLACES: places_q  <= cfg_data[PlacesW-1:0];
				REG_MINIMUM_AMOUNT: minimum_q <= cfg_data;
				default:            places_q  <= places_q;
			endcase
		end
	end

	// places above the table act as the largest entry
	assign places_eff = (places_q > PLACES_MAX) ? PLACES_MAX : places_q;

	dap_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.places    (places_eff),
		.chars     (chars),
		.fin_valid (fin_valid),
		.fin_ready (fin_ready),
		.fin       (fin)
	);

	dap_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.minimum   (minimum_q),
		.fin_valid (fin_valid),
		.fin_ready (fin_ready),
		.fin       (fin),
		.result    (result)
	);

endmodule

FILE: sv/dap_scan.sv
// ---------------------------------------------------------------------------
// dap_scan: byte scanner of the amount parser
// Registers each byte, updates the per-string state in one step and, on
// the last byte, hands the finished string to the scaling pipeline.
// ---------------------------------------------------------------------------
module dap_scan (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [dap_pkg::PlacesW-1:0]    places,
	dap_byte_if.sink                       chars,
	output logic                           fin_valid,
	input  logic                           fin_ready,
	output dap_pkg::fin_t                  fin
);
	import dap_pkg::*;

	// input register
	logic       v_s1;
	logic [7:0] char_s1;
	logic       has_s1;
	logic       last_s1;
	logic       go_s1;

	// string state
	logic [AmountW-1:0] accum_q, accum_d;
	logic               ovf_q, ovf_d;
	logic               bad_q, bad_d;
	logic               point_q, point_d;
	logic [PlacesW-1:0] flen_q, flen_d;
	logic               exc_q, exc_d;
	logic               content_q, content_d;
	logic [PlacesW-1:0] pend_q, pend_d;
	logic               nonempty_q, nonempty_d;

	logic               fin_v_q;
	fin_t               fin_q;
	fin_t               fin_d;

	function automatic logic [PlacesW-1:0] sat5(input logic [PlacesW:0] s);
		return s[PlacesW] ? COUNT_SAT : s[PlacesW-1:0];
	endfunction

	// a byte leaves s1 unless it ends a string and the handoff is full
	assign go_s1       = v_s1 && (!last_s1 || !fin_v_q || fin_ready);
	assign chars.ready = !v_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (chars.valid && chars.ready) begin
			v_s1 <= 1'b1;
		end else if (go_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_code;
			has_s1  <= chars.has_char;
			last_s1 <= chars.last_char;
		end
	end

	// next string state for the byte in s1
	always_comb begin
		logic               space;
		logic               digit;
		logic               beyond;
		logic [PlacesW-1:0] flen_mid;
		logic [PlacesW:0]   flen_sum;
		logic [PlacesW-1:0] used;
		logic [AmountW+3:0] acc10;

		accum_d    = accum_q;
		ovf_d      = ovf_q;
		bad_d      = bad_q;
		point_d    = point_q;
		flen_d     = flen_q;
		exc_d      = exc_q;
		content_d  = content_q;
		pend_d     = pend_q;
		nonempty_d = nonempty_q;

		space    = (char_s1 == CHAR_SPACE) || (char_s1 >= CHAR_TAB && char_s1 <= CHAR_CR);
		digit    = (char_s1 >= CHAR_ZERO) && (char_s1 <= CHAR_NINE);
		beyond   = 1'b0;
		flen_mid = flen_q;
		flen_sum = {1'b0, flen_q} + {1'b0, pend_q};
		acc10    = ({4'b0, accum_q} << 3) + ({4'b0, accum_q} << 1)
			+ {{AmountW{1'b0}}, char_s1[3:0] - CHAR_ZERO[3:0]};

		if (has_s1) begin
			if (space) begin
				if (content_q) begin
					pend_d = sat5({1'b0, pend_q} + 6'd1);
				end
			end else begin
				content_d = 1'b1;
				// whitespace after content and followed by more content counts as bad characters
				if (pend_q != '0) begin
					bad_d      = 1'b1;
					nonempty_d = 1'b1;
					if (point_q) begin
						if (flen_sum > {1'b0, places}) begin
							exc_d = 1'b1;
						end
						flen_mid = sat5(flen_sum);
					end
					pend_d = '0;
				end
				flen_d = flen_mid;
				if (char_s1 == CHAR_COMMA) begin
					flen_d = flen_mid;
				end else if (char_s1 == CHAR_POINT && !point_q) begin
					point_d = 1'b1;
				end else begin
					nonempty_d = 1'b1;
					if (point_q) begin
						beyond = flen_mid >= places;
						if (beyond && char_s1 != CHAR_ZERO) begin
							exc_d = 1'b1;
						end
						flen_d = sat5({1'b0, flen_mid} + 6'd1);
					end
					if (digit) begin
						if (!beyond && !ovf_q) begin
							if (acc10[AmountW+3:AmountW] != '0) begin
								ovf_d = 1'b1;
							end else begin
								accum_d = acc10[AmountW-1:0];
							end
						end
					end else begin
						bad_d = 1'b1;
					end
				end
			end
		end

		// finished string record
		used        = (flen_d < places) ? flen_d : places;
		fin_d.accum = accum_d;
		fin_d.exp   = places - used;
		if (exc_d) begin
			fin_d.code = ST_TOO_MANY_DECIMALS;
		end else if (!nonempty_d) begin
			fin_d.code = ST_EMPTY;
		end else if (bad_d) begin
			fin_d.code = ST_BAD_CHAR;
		end else if (ovf_d) begin
			fin_d.code = ST_OVERFLOW;
		end else begin
			fin_d.code = ST_OK;
		end
	end

	// string state, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q    <= '0;
			ovf_q      <= 1'b0;
			bad_q      <= 1'b0;
			point_q    <= 1'b0;
			flen_q     <= '0;
			exc_q      <= 1'b0;
			content_q  <= 1'b0;
			pend_q     <= '0;
			nonempty_q <= 1'b0;
		end else if (go_s1) begin
			if (last_s1) begin
				accum_q    <= '0;
				ovf_q      <= 1'b0;
				bad_q      <= 1'b0;
				point_q    <= 1'b0;
				flen_q     <= '0;
				exc_q      <= 1'b0;
				content_q  <= 1'b0;
				pend_q     <= '0;
				nonempty_q <= 1'b0;
			end else begin
				accum_q    <= accum_d;
				ovf_q      <= ovf_d;
				bad_q      <= bad_d;
				point_q    <= point_d;
				flen_q     <= flen_d;
				exc_q      <= exc_d;
				content_q  <= content_d;
				pend_q     <= pend_d;
				nonempty_q <= nonempty_d;
			end
		end
	end

	// handoff register to the scaling pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_v_q <= 1'b0;
		end else if (go_s1 && last_s1) begin
			fin_v_q <= 1'b1;
		end else if (fin_ready) begin
			fin_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			fin_q <= fin_d;
		end
	end

	assign fin_valid = fin_v_q;
	assign fin       = fin_q;

	// pending whitespace only counts after content
	a_pend_after_content: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != '0 |-> content_q)
		else $error("pending whitespace without content");

	// fraction positions only exist after a point
	a_flen_needs_point: assert property (@(posedge clk) disable iff (!arst_n)
		flen_q != '0 |-> point_q)
		else $error("fraction length without point");

	// a stalled handoff keeps its record
	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fin_v_q && !fin_ready |=> fin_v_q && $stable(fin_q))
		else $error("handoff record lost while stalled");

endmodule

FILE: sv/dap_scale.sv
// ---------------------------------------------------------------------------
// dap_scale: scaling pipeline of the amount parser
// Multiplies the digits by the missing power of ten in 32-bit partial
// products, checks 64-bit overflow and the minimum, and holds the result.
// ---------------------------------------------------------------------------
module dap_scale (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [dap_pkg::AmountW-1:0] minimum,
	input  logic                        fin_valid,
	output logic                        fin_ready,
	input  dap_pkg::fin_t               fin,
	dap_result_if.source                result
);
	import dap_pkg::*;

	localparam int HalfW = AmountW / 2;

	logic               v_s3, v_s4, v_s5, out_v_q;
	logic               rdy_s3, rdy_s4, rdy_s5, rdy_out;

	logic [AmountW-1:0] ll_s3, lh_s3, hl_s3;
	logic               hh_nz_s3;
	status_t            code_s3;

	logic [AmountW-1:0] ll_s4;
	logic [AmountW:0]   mid_s4;
	logic               hh_nz_s4;
	status_t            code_s4;

	logic [AmountW-1:0] value_s5;
	status_t            code_s5;

	logic [AmountW-1:0] amount_q;
	status_t            status_q;

	logic [AmountW-1:0] scale;
	logic [AmountW:0]   low_sum;
	logic               ovf;

	// each stage moves on when the next one is free
	assign rdy_out   = !out_v_q || result.ready;
	assign rdy_s5    = !v_s5 || rdy_out;
	assign rdy_s4    = !v_s4 || rdy_s5;
	assign rdy_s3    = !v_s3 || rdy_s4;
	assign fin_ready = rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (rdy_s3) begin
				v_s3 <= fin_valid;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
			if (rdy_s5) begin
				v_s5 <= v_s4;
			end
			if (rdy_out) begin
				out_v_q <= v_s5;
			end
		end
	end

	// partial products; the high-high product only matters if nonzero
	assign scale = pow10(fin.exp);

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			ll_s3    <= fin.accum[HalfW-1:0] * scale[HalfW-1:0];
			lh_s3    <= fin.accum[HalfW-1:0] * scale[AmountW-1:HalfW];
			hl_s3    <= fin.accum[AmountW-1:HalfW] * scale[HalfW-1:0];
			hh_nz_s3 <= (fin.accum[AmountW-1:HalfW] != '0) && (scale[AmountW-1:HalfW] != '0);
			code_s3  <= fin.code;
		end
	end

	// middle sum
	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			ll_s4    <= ll_s3;
			mid_s4   <= {1'b0, lh_s3} + {1'b0, hl_s3};
			hh_nz_s4 <= hh_nz_s3;
			code_s4  <= code_s3;
		end
	end

	// final product and overflow past 64 bits
	assign low_sum = {1'b0, ll_s4} + {1'b0, mid_s4[HalfW-1:0], {HalfW{1'b0}}};
	assign ovf     = hh_nz_s4 || (mid_s4[AmountW:HalfW] != '0) || low_sum[AmountW];

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			value_s5 <= low_sum[AmountW-1:0];
			code_s5  <= (code_s4 == ST_OK && ovf) ? ST_OVERFLOW : code_s4;
		end
	end

	// result register with minimum check
	always_ff @(posedge clk) begin
		if (rdy_out) begin
			if (code_s5 != ST_OK) begin
				status_q <= code_s5;
				amount_q <= '0;
			end else if (value_s5 < minimum) begin
				status_q <= ST_BELOW_MIN;
				amount_q <= '0;
			end else begin
				status_q <= ST_OK;
				amount_q <= value_s5;
			end
		end
	end

	assign result.valid  = out_v_q;
	assign result.amount = amount_q;
	assign result.status = status_q;

	// failed results carry no amount
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && status_q != ST_OK |-> amount_q == '0)
		else $error("nonzero amount with failing status");

	// an accepted amount meets the minimum
	a_ok_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && status_q == ST_OK |-> amount_q >= minimum)
		else $error("accepted amount below minimum");

	// a blocked middle stage keeps its item
	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !rdy_s5 |=> v_s4 && $stable(mid_s4))
		else $error("pipeline item dropped while stalled");

endmodule

FILE: dv/testbench.sv
// ---------------------------------------------------------------------------
// testbench: self-checking regression for decimal_amount_parser
// Feeds amount text byte by byte through the chars channel, predicts each
// string's scaled amount and status, and compares every result transaction
// in order. Walks several register settings, with random sender bursts,
// receiver stalls and one long result hold-off.
// ---------------------------------------------------------------------------
module testbench;
	import dap_pkg::*;

	localparam int          WATCHDOG_LIMIT = 2000;
	localparam int          DRAIN_CYCLES   = 12;
	localparam int          LONG_HOLD      = 400;
	localparam int          PHASE_ITEMS    = 190;
	localparam int          N_PHASES       = 8;
	localparam int          MAX_PRINTS     = 50;
	localparam logic [63:0] U64_MAX        = '1;

	typedef struct packed {
		logic [7:0] char_code;
		logic       has_char;
		logic       last_char;
	} text_item_t;

	typedef struct packed {
		logic [63:0] amount;
		status_t     status;
	} parse_result_t;

	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_HALF,
		RX_SPARSE,
		RX_PATTERN
	} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wen;
	reg_index_t  cfg_index;
	logic [63:0] cfg_data;

	dap_byte_if   chars_if();
	dap_result_if result_if();

	decimal_amount_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.chars     (chars_if),
		.result    (result_if)
	);

	// stimulus and expectation stores
	text_item_t    text_q[$];
	parse_result_t pending_results[$];
	int            mismatches = 0;
	int            idle_cycles = 0;

	// driver state
	text_item_t cur_item = '0;
	bit         in_busy = 1'b0;
	bit         byte_taken = 1'b0;
	bit         result_taken = 1'b0;
	int         gap_left = 0;
	int         burst_left = 0;

	// receiver state
	bit         hold_request = 1'b0;
	int         hold_left = 0;
	int         mode_left = 0;
	rx_mode_t   rx_mode = RX_ALWAYS;
	logic [7:0] rx_pattern = 8'hB2;
	logic       rx_ready;

	// predictor: register copies and per-string scan state
	logic [4:0]  shadow_places = 5'd2;
	logic [63:0] shadow_min = 64'd1;
	logic [63:0] digits_acc = '0;
	bit          digits_ovf = 1'b0;
	bit          bad_seen = 1'b0;
	bit          point_seen = 1'b0;
	bit          frac_excess = 1'b0;
	bit          text_started = 1'b0;
	bit          any_content = 1'b0;
	int unsigned frac_len = 0;
	int unsigned space_run = 0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int unsigned sat5(int unsigned v);
		return (v > COUNT_SAT) ? COUNT_SAT : v;
	endfunction

	function automatic int unsigned active_places();
		return (shadow_places > PLACES_MAX) ? PLACES_MAX : shadow_places;
	endfunction

	function automatic logic [63:0] pow10_of(int unsigned n);
		logic [63:0] p;
		p = 64'd1;
		repeat (n) p = p * 64'd10;
		return p;
	endfunction

	function automatic bit is_blank(logic [7:0] c);
		return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
	endfunction

	// advance the scan state by one text byte
	function automatic void scan_byte(logic [7:0] c);
		int unsigned places;
		bit          beyond;
		logic [63:0] d;
		places = active_places();
		if (is_blank(c)) begin
			if (text_started) space_run = sat5(space_run + 1);
			return;
		end
		text_started = 1'b1;

		// whitespace with content after it is interior, hence bad
		if (space_run != 0) begin
			bad_seen = 1'b1;
			any_content = 1'b1;
			if (point_seen) begin
				if (frac_len + space_run > places) frac_excess = 1'b1;
				frac_len = sat5(frac_len + space_run);
			end
			space_run = 0;
		end

		if (c == CHAR_COMMA) return;
		if (c == CHAR_POINT && !point_seen) begin
			point_seen = 1'b1;
			return;
		end

		any_content = 1'b1;
		beyond = 1'b0;
		if (point_seen) begin
			beyond = frac_len >= places;
			if (beyond && c != CHAR_ZERO) frac_excess = 1'b1;
			frac_len = sat5(frac_len + 1);
		end
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			d = {56'd0, c - CHAR_ZERO};
			if (!beyond && !digits_ovf) begin
				if (digits_acc > (U64_MAX - d) / 64'd10) digits_ovf = 1'b1;
				else digits_acc = digits_acc * 64'd10 + d;
			end
		end else begin
			bad_seen = 1'b1;
		end
	endfunction

	// end of string: scale, classify, then clear the scan state
	function automatic parse_result_t close_string();
		int unsigned   places;
		int unsigned   used;
		logic [63:0]   scale;
		logic [63:0]   value;
		parse_result_t r;
		places = active_places();
		used = (frac_len < places) ? frac_len : places;
		scale = pow10_of(places - used);
		value = '0;
		if (frac_excess) r.status = ST_TOO_MANY_DECIMALS;
		else if (!any_content) r.status = ST_EMPTY;
		else if (bad_seen) r.status = ST_BAD_CHAR;
		else if (digits_ovf || digits_acc > U64_MAX / scale) r.status = ST_OVERFLOW;
		else begin
			value = digits_acc * scale;
			r.status = (value < shadow_min) ? ST_BELOW_MIN : ST_OK;
		end
		r.amount = (r.status == ST_OK) ? value : '0;

		digits_acc = '0;
		digits_ovf = 1'b0;
		bad_seen = 1'b0;
		point_seen = 1'b0;
		frac_len = 0;
		frac_excess = 1'b0;
		text_started = 1'b0;
		space_run = 0;
		any_content = 1'b0;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		if (mismatches < MAX_PRINTS)
			$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	function automatic logic [7:0] blank_char();
		return ($urandom_range(0, 5) == 0) ? CHAR_SPACE : 8'($urandom_range(CHAR_TAB, CHAR_CR));
	endfunction

	// queue one string; returns the number of transactions that carry it, no-ops not counted
	function automatic int push_string(logic [7:0] txt[$], bit empty_end);
		text_item_t it;
		int         count;
		count = 0;
		for (int i = 0; i < txt.size(); i++) begin
			// has_char low without last_char: a no-op transaction
			if ($urandom_range(0, 19) == 0) begin
				it.char_code = 8'($urandom_range(0, 255));
				it.has_char = 1'b0;
				it.last_char = 1'b0;
				text_q.insert(text_q.size(), it);
			end
			it.char_code = txt[i];
			it.has_char = 1'b1;
			it.last_char = !empty_end && (i == txt.size() - 1);
			text_q.insert(text_q.size(), it);
			count++;
		end
		if (empty_end || txt.size() == 0) begin
			it.char_code = 8'($urandom_range(0, 255));
			it.has_char = 1'b0;
			it.last_char = 1'b1;
			text_q.insert(text_q.size(), it);
			count++;
		end
		return count;
	endfunction

	function automatic int queue_text(string s, bit empty_end);
		logic [7:0] txt[$];
		for (int i = 0; i < s.len(); i++) txt.insert(txt.size(), s[i]);
		return push_string(txt, empty_end);
	endfunction

	// mostly well-formed amounts with random content, some broken ones
	function automatic int queue_random_string(int unsigned places);
		logic [7:0]  txt[$];
		int unsigned pick;
		int unsigned n;
		logic [63:0] lim;
		string       s;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2)) txt.insert(txt.size(), blank_char());

		if (pick < 4) begin
			// nothing but blanks, commas or a lone point
			repeat ($urandom_range(0, 3))
				txt.insert(txt.size(),
					($urandom_range(0, 1) == 0) ? CHAR_COMMA : blank_char());
			if ($urandom_range(0, 1) == 0) txt.insert(txt.size(), CHAR_POINT);
		end else if (pick < 12) begin
			// right at the 64-bit edge once scaled
			lim = U64_MAX / pow10_of(places);
			s = $sformatf("%0d", lim - 64'd1 + 64'($urandom_range(0, 2)));
			for (int i = 0; i < s.len(); i++) txt.insert(txt.size(), s[i]);
		end else begin
			n = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 21) : $urandom_range(0, 6);
			repeat (n) begin
				txt.insert(txt.size(), 8'(CHAR_ZERO + $urandom_range(0, 9)));
				if ($urandom_range(0, 9) == 0) txt.insert(txt.size(), CHAR_COMMA);
			end
			if ($urandom_range(0, 9) < 6) begin
				txt.insert(txt.size(), CHAR_POINT);
				repeat ($urandom_range(0, places + 1))
					txt.insert(txt.size(), 8'(CHAR_ZERO + $urandom_range(0, 9)));
				if ($urandom_range(0, 2) == 0)
					repeat ($urandom_range(1, 4)) txt.insert(txt.size(), CHAR_ZERO);
			end
		end

		// corruptions: random byte, interior blank, extra point
		if ($urandom_range(0, 6) == 0) begin
			case ($urandom_range(0, 2))
				0: txt.insert($urandom_range(0, txt.size()), 8'($urandom_range(0, 255)));
				1: txt.insert($urandom_range(0, txt.size()), blank_char());
				default: txt.insert($urandom_range(0, txt.size()), CHAR_POINT);
			endcase
		end

		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) txt.insert(txt.size(), blank_char());
		return push_string(txt, $urandom_range(0, 9) == 0);
	endfunction

	task automatic write_reg(reg_index_t idx, logic [63:0] data);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_wen <= 1'b0;
		if (idx == REG_DECIMAL_PLACES) shadow_places = data[4:0];
		else shadow_min = data;
	endtask

	task automatic wait_drained();
		while (text_q.size() != 0 || in_busy || pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// byte driver: bursts of transactions separated by random gaps
	always @(negedge clk) begin
		if (byte_taken) in_busy = 1'b0;
		if (!in_busy) begin
			if (gap_left != 0) begin
				gap_left--;
			end else if (text_q.size() != 0) begin
				cur_item = text_q.pop_front();
				in_busy = 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
						: $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
		end
		chars_if.valid <= in_busy;
		chars_if.char_code <= cur_item.char_code;
		chars_if.has_char <= cur_item.has_char;
		chars_if.last_char <= cur_item.last_char;
	end

	// result receiver: stall modes of its own plus one long hold-off
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = LONG_HOLD;
			hold_request = 1'b0;
		end
		if (mode_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(16, 128);
			rx_pattern = 8'($urandom_range(1, 255));
		end else begin
			mode_left--;
		end
		rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
		if (hold_left != 0) begin
			hold_left--;
			rx_ready = 1'b0;
		end else begin
			case (rx_mode)
				RX_ALWAYS: rx_ready = 1'b1;
				RX_HALF:   rx_ready = 1'($urandom_range(0, 1));
				RX_SPARSE: rx_ready = ($urandom_range(0, 3) == 0);
				default:   rx_ready = rx_pattern[0];
			endcase
		end
		result_if.ready <= rx_ready;
	end

	// monitor: predict on accepted bytes, check accepted results, watchdog
	always @(posedge clk) begin
		parse_result_t want;
		if (!arst_n) begin
			byte_taken = 1'b0;
			result_taken = 1'b0;
		end else begin
			byte_taken = chars_if.valid && chars_if.ready;
			result_taken = result_if.valid && result_if.ready;
			if (byte_taken) begin
				if (chars_if.has_char) scan_byte(chars_if.char_code);
				if (chars_if.last_char)
					pending_results.insert(pending_results.size(), close_string());
			end
			if (result_taken) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result, status", 64'(result_if.status), '0);
				end else begin
					want = pending_results.pop_front();
					if (result_if.amount !== want.amount)
						report_mismatch("amount", result_if.amount, want.amount);
					if (result_if.status !== want.status)
						report_mismatch("status", 64'(result_if.status), 64'(want.status));
				end
			end
			if (byte_taken || result_taken) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("[FAIL] regression broken");
					$finish;
				end
			end
		end
	end

	// main sequence: reset, directed strings, then randomized phases
	initial begin
		int          sent;
		logic [4:0]  places_val;
		logic [63:0] min_val;
		logic [63:0] data;
		logic [7:0]  raw[$];
		text_item_t  noop;

		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = REG_DECIMAL_PLACES;
		cfg_data = '0;
		chars_if.valid = 1'b0;
		chars_if.char_code = '0;
		chars_if.has_char = 1'b0;
		chars_if.last_char = 1'b0;
		result_if.ready = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed strings under reset settings (2 places, minimum 1)
		sent = push_string(raw, 1'b1);
		sent += queue_text(" 1,2\t", 1'b0);
		sent += queue_text("1 2", 1'b0);
		sent += queue_text("1.500", 1'b0);
		sent += queue_text("1.001", 1'b0);
		sent += queue_text("1..2", 1'b0);
		noop.char_code = 8'hFF;
		noop.has_char = 1'b0;
		noop.last_char = 1'b0;
		text_q.insert(text_q.size(), noop);
		raw.insert(raw.size(), 8'h00);
		raw.insert(raw.size(), 8'hFF);
		sent += push_string(raw, 1'b0);
		sent += queue_text("0", 1'b0);
		sent += queue_text("7", 1'b1);
		wait_drained();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: begin places_val = 5'd0;  min_val = 64'd0; end
				1: begin places_val = 5'd19; min_val = 64'd0; end
				2: begin places_val = 5'd31; min_val = 64'd1; end
				3: begin places_val = 5'd5;  min_val = 64'($urandom_range(0, 1000000)); end
				4: begin places_val = 5'd2;  min_val = U64_MAX; end
				5: begin places_val = 5'd20; min_val = 64'd100; end
				6: begin
					places_val = 5'($urandom_range(0, 31));
					min_val = {$urandom, $urandom} >> $urandom_range(0, 63);
				end
				default: begin places_val = 5'd3; min_val = 64'd1; end
			endcase
			data = {$urandom, $urandom};
			data[4:0] = places_val;
			write_reg(REG_DECIMAL_PLACES, data);
			write_reg(REG_MINIMUM_AMOUNT, min_val);
			if (ph == 2) hold_request = 1'b1;
			sent = 0;
			while (sent < PHASE_ITEMS) sent += queue_random_string(active_places());
			wait_drained();
		end

		if (mismatches == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end

endmodule
